// ===== hw/rtl/seconds_to_civil_datetime_defines.svh =====
// assertion macros for the seconds to civil datetime converter
// included by the top level; no other dependencies
`ifndef SECONDS_TO_CIVIL_DATETIME_DEFINES_SVH
`define SECONDS_TO_CIVIL_DATETIME_DEFINES_SVH
`ifndef ASSERT_OFF
`define STCD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stcd: same-cycle check failed");
`define STCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stcd: next-cycle check failed");
`else
`define STCD_ASSERT_IMP(label, clk, rstn, ante, cons)
`define STCD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/stcd_pkg.sv =====
// shared widths, constants and beat structs of the seconds to civil datetime converter
// no dependencies
package stcd_pkg;

    localparam int EPOCH_W   = 39;
    localparam int TZ_W      = 12;
    localparam int TZ_SECS_W = 18;
    localparam int SUM_W     = 41;
    localparam int SECS_W    = 39;
    localparam int DAYS_W    = 22;
    localparam int SOD_W     = 17;
    localparam int REM_W     = 12;
    localparam int ERA_W     = 5;
    localparam int DOE_W     = 18;
    localparam int YOE_W     = 9;
    localparam int DOY_W     = 9;
    localparam int MP_W      = 4;
    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int SEC_W     = 6;

    // seconds from 0000-03-01 to 1970-01-01, and the last second of 9999-12-31 on that scale
    localparam logic signed [SUM_W-1:0] BASE_SECS = 41'sd62162035200;
    localparam logic [SECS_W-1:0]       MAX_SECS  = 39'd315564335999;

    localparam logic [SOD_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [DOE_W-1:0] DAYS_PER_ERA  = 18'd146097;
    localparam logic [DOE_W-1:0] DOE_LAST      = 18'd146096;
    localparam logic [11:0]      SECS_PER_HOUR = 12'd3600;
    localparam logic [6:0]       SECS_PER_MIN  = 7'd60;
    localparam logic [8:0]       YEAR_DAYS     = 9'd365;
    localparam logic [8:0]       YEARS_PER_ERA = 9'd400;
    localparam logic [2:0]       MP_SCALE      = 3'd5;
    localparam logic [1:0]       MP_BIAS       = 2'd2;
    localparam logic [MP_W-1:0]  MP_JAN        = 4'd10;
    localparam logic [MP_W-1:0]  MP_TO_MONTH   = 4'd3;
    localparam logic [MP_W-1:0]  MP_WRAP       = 4'd9;

    // reciprocals for exact floor division by constants: q = (x * RCP) >> SH
    // shift = input bits + divisor bits, except the day split, whose input stays below 2^31.2
    localparam int SH_DAY   = 41;
    localparam int SH_ERA   = 40;
    localparam int SH_HOUR  = 29;
    localparam int SH_1460  = 29;
    localparam int SH_36524 = 34;
    localparam int SH_MIN   = 18;
    localparam int SH_YEAR  = 27;
    localparam int SH_CENT  = 16;
    localparam int SH_MP    = 19;

    localparam logic [31:0] RCP_DAY   = 32'(((64'd1 << SH_DAY) + 64'd674) / 64'd675);
    localparam logic [22:0] RCP_ERA   = 23'(((64'd1 << SH_ERA) + 64'd146096) / 64'd146097);
    localparam logic [17:0] RCP_HOUR  = 18'(((64'd1 << SH_HOUR) + 64'd3599) / 64'd3600);
    localparam logic [18:0] RCP_1460  = 19'(((64'd1 << SH_1460) + 64'd1459) / 64'd1460);
    localparam logic [18:0] RCP_36524 = 19'(((64'd1 << SH_36524) + 64'd36523) / 64'd36524);
    localparam logic [12:0] RCP_MIN   = 13'(((64'd1 << SH_MIN) + 64'd59) / 64'd60);
    localparam logic [18:0] RCP_YEAR  = 19'(((64'd1 << SH_YEAR) + 64'd364) / 64'd365);
    localparam logic [9:0]  RCP_CENT  = 10'(((64'd1 << SH_CENT) + 64'd99) / 64'd100);
    localparam logic [11:0] RCP_MP    = 12'(((64'd1 << SH_MP) + 64'd152) / 64'd153);

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [SOD_W-1:0]  sod;
        logic              oor;
    } day_split_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } clock_t;

    typedef struct packed {
        logic [ERA_W-1:0] era;
        logic [DOE_W-1:0] doe;
        logic [DOE_W-1:0] yoe_days;
        clock_t           tod;
        logic             oor;
    } era_clock_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        clock_t             tod;
        logic               oor;
    } civil_t;

endpackage

// ===== hw/rtl/stcd_day_split.sv =====
// stages 1-4: zone offset add, range clamp, day number and second of day
// depends on stcd_pkg
module stcd_day_split
    import stcd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [EPOCH_W-1:0]   epoch_seconds,
    input  logic signed [TZ_SECS_W-1:0] tz_secs,
    output logic                        out_valid,
    input  logic                        out_stall,
    output day_split_t                  out_beat
);

    logic [3:0] vld_reg;
    logic [3:0] take;

    logic signed [SUM_W-1:0] st1_sum_reg, st1_sum_next;
    logic [SECS_W-1:0]       st2_secs_reg, st2_secs_next;
    logic                    st2_oor_reg, st2_oor_next;
    logic [DAYS_W-1:0]       st3_days_reg, st3_days_next;
    logic [SECS_W-1:0]       st3_secs_reg;
    logic                    st3_oor_reg;
    day_split_t              st4_reg, st4_next;

    logic [63:0]       day_prod;
    logic [SECS_W-1:0] day_secs;
    logic [SECS_W-1:0] sod_full;

    // a stage loads when it is empty or its beat moves on
    always_comb
    begin
        take[3] = !vld_reg[3] || !out_stall;
        for (int k = 2; k >= 0; k--)
        begin
            take[k] = !vld_reg[k] || take[k+1];
        end
    end

    assign in_stall  = !take[0];
    assign out_valid = vld_reg[3];
    assign out_beat  = st4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (take[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < 4; k++)
            begin
                if (take[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // local seconds counted from 0000-03-01
    assign st1_sum_next = {{(SUM_W-EPOCH_W){epoch_seconds[EPOCH_W-1]}}, epoch_seconds}
                        + {{(SUM_W-TZ_SECS_W){tz_secs[TZ_SECS_W-1]}}, tz_secs}
                        + BASE_SECS;

    always_comb
    begin
        if (st1_sum_reg[SUM_W-1])
        begin
            st2_secs_next = '0;
            st2_oor_next  = 1'b1;
        end
        else if (st1_sum_reg[SUM_W-2:0] > (SUM_W-1)'(MAX_SECS))
        begin
            st2_secs_next = MAX_SECS;
            st2_oor_next  = 1'b1;
        end
        else
        begin
            st2_secs_next = st1_sum_reg[SECS_W-1:0];
            st2_oor_next  = 1'b0;
        end
    end

    // 86400 = 128 * 675
    assign day_prod      = 64'(st2_secs_reg[SECS_W-1:7]) * 64'(RCP_DAY);
    assign st3_days_next = day_prod[SH_DAY+DAYS_W-1:SH_DAY];

    assign day_secs = SECS_W'(st3_days_reg) * SECS_W'(SECS_PER_DAY);
    assign sod_full = st3_secs_reg - day_secs;

    always_comb
    begin
        st4_next.days = st3_days_reg;
        st4_next.sod  = sod_full[SOD_W-1:0];
        st4_next.oor  = st3_oor_reg;
    end

    always_ff @(posedge clk)
    begin
        if (take[0])
        begin
            st1_sum_reg <= st1_sum_next;
        end
        if (take[1])
        begin
            st2_secs_reg <= st2_secs_next;
            st2_oor_reg  <= st2_oor_next;
        end
        if (take[2])
        begin
            st3_days_reg <= st3_days_next;
            st3_secs_reg <= st2_secs_reg;
            st3_oor_reg  <= st2_oor_reg;
        end
        if (take[3])
        begin
            st4_reg <= st4_next;
        end
    end

endmodule

// ===== hw/rtl/stcd_era_clock.sv =====
// stages 5-8: era and day of era, hour/minute/second, leap-corrected day count
// depends on stcd_pkg
module stcd_era_clock
    import stcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  day_split_t in_beat,
    output logic       out_valid,
    input  logic       out_stall,
    output era_clock_t out_beat
);

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [SOD_W-1:0]  sod;
        logic [ERA_W-1:0]  era;
        logic [HOUR_W-1:0] hour;
        logic              oor;
    } st5_t;

    typedef struct packed {
        logic [DOE_W-1:0]  doe;
        logic [REM_W-1:0]  rem;
        logic [ERA_W-1:0]  era;
        logic [HOUR_W-1:0] hour;
        logic              oor;
    } st6_t;

    typedef struct packed {
        logic [DOE_W-1:0]  doe;
        logic [REM_W-1:0]  rem;
        logic [ERA_W-1:0]  era;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [6:0]        q1460;
        logic [2:0]        q36524;
        logic              last;
        logic              oor;
    } st7_t;

    logic [3:0] vld_reg;
    logic [3:0] take;

    st5_t       st5_reg, st5_next;
    st6_t       st6_reg, st6_next;
    st7_t       st7_reg, st7_next;
    era_clock_t st8_reg, st8_next;

    logic [44:0] era_prod;
    logic [34:0] hour_prod;
    logic [22:0] era_days;
    logic [22:0] doe_full;
    logic [SOD_W-1:0] hour_secs;
    logic [SOD_W-1:0] rem_full;
    logic [36:0] p1460;
    logic [36:0] p36524;
    logic [24:0] min_prod;
    logic [REM_W-1:0] min_secs;
    logic [REM_W-1:0] sec_full;

    always_comb
    begin
        take[3] = !vld_reg[3] || !out_stall;
        for (int k = 2; k >= 0; k--)
        begin
            take[k] = !vld_reg[k] || take[k+1];
        end
    end

    assign in_stall  = !take[0];
    assign out_valid = vld_reg[3];
    assign out_beat  = st8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (take[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < 4; k++)
            begin
                if (take[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign era_prod  = 45'(in_beat.days) * 45'(RCP_ERA);
    assign hour_prod = 35'(in_beat.sod) * 35'(RCP_HOUR);

    always_comb
    begin
        st5_next.days = in_beat.days;
        st5_next.sod  = in_beat.sod;
        st5_next.era  = era_prod[SH_ERA+ERA_W-1:SH_ERA];
        st5_next.hour = hour_prod[SH_HOUR+HOUR_W-1:SH_HOUR];
        st5_next.oor  = in_beat.oor;
    end

    assign era_days  = 23'(st5_reg.era) * 23'(DAYS_PER_ERA);
    assign doe_full  = 23'(st5_reg.days) - era_days;
    assign hour_secs = SOD_W'(st5_reg.hour) * SOD_W'(SECS_PER_HOUR);
    assign rem_full  = st5_reg.sod - hour_secs;

    always_comb
    begin
        st6_next.doe  = doe_full[DOE_W-1:0];
        st6_next.rem  = rem_full[REM_W-1:0];
        st6_next.era  = st5_reg.era;
        st6_next.hour = st5_reg.hour;
        st6_next.oor  = st5_reg.oor;
    end

    // doe/1460, doe/36524 and doe/146096 drop the leap days from the day count
    assign p1460    = 37'(st6_reg.doe) * 37'(RCP_1460);
    assign p36524   = 37'(st6_reg.doe) * 37'(RCP_36524);
    assign min_prod = 25'(st6_reg.rem) * 25'(RCP_MIN);

    always_comb
    begin
        st7_next.doe    = st6_reg.doe;
        st7_next.rem    = st6_reg.rem;
        st7_next.era    = st6_reg.era;
        st7_next.hour   = st6_reg.hour;
        st7_next.minute = min_prod[SH_MIN+MIN_W-1:SH_MIN];
        st7_next.q1460  = p1460[SH_1460+6:SH_1460];
        st7_next.q36524 = p36524[SH_36524+2:SH_36524];
        st7_next.last   = (st6_reg.doe == DOE_LAST);
        st7_next.oor    = st6_reg.oor;
    end

    assign min_secs = REM_W'(st7_reg.minute) * REM_W'(SECS_PER_MIN);
    assign sec_full = st7_reg.rem - min_secs;

    always_comb
    begin
        st8_next.era        = st7_reg.era;
        st8_next.doe        = st7_reg.doe;
        st8_next.yoe_days   = st7_reg.doe - DOE_W'(st7_reg.q1460) + DOE_W'(st7_reg.q36524)
                            - DOE_W'(st7_reg.last);
        st8_next.tod.hour   = st7_reg.hour;
        st8_next.tod.minute = st7_reg.minute;
        st8_next.tod.second = sec_full[SEC_W-1:0];
        st8_next.oor        = st7_reg.oor;
    end

    always_ff @(posedge clk)
    begin
        if (take[0])
        begin
            st5_reg <= st5_next;
        end
        if (take[1])
        begin
            st6_reg <= st6_next;
        end
        if (take[2])
        begin
            st7_reg <= st7_next;
        end
        if (take[3])
        begin
            st8_reg <= st8_next;
        end
    end

endmodule

// ===== hw/rtl/stcd_year_date.sv =====
// stages 9-12: year of era, day of year, March-based month, final calendar fields
// depends on stcd_pkg
module stcd_year_date
    import stcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  era_clock_t in_beat,
    output logic       out_valid,
    input  logic       out_stall,
    output civil_t     out_beat
);

    typedef struct packed {
        logic [YOE_W-1:0] yoe;
        logic [DOE_W-1:0] doe;
        logic [ERA_W-1:0] era;
        clock_t           tod;
        logic             oor;
    } st9_t;

    typedef struct packed {
        logic [DOY_W-1:0] doy;
        logic [YOE_W-1:0] yoe;
        logic [ERA_W-1:0] era;
        clock_t           tod;
        logic             oor;
    } st10_t;

    typedef struct packed {
        logic [MP_W-1:0]  mp;
        logic [DOY_W-1:0] doy;
        logic [YOE_W-1:0] yoe;
        logic [ERA_W-1:0] era;
        clock_t           tod;
        logic             oor;
    } st11_t;

    logic [3:0] vld_reg;
    logic [3:0] take;

    st9_t   st9_reg, st9_next;
    st10_t  st10_reg, st10_next;
    st11_t  st11_reg, st11_next;
    civil_t st12_reg, st12_next;

    logic [36:0]      yoe_prod;
    logic [18:0]      cent_prod;
    logic [DOE_W-1:0] year_days;
    logic [DOE_W-1:0] doy_full;
    logic [10:0]      mp_arg;
    logic [22:0]      mp_prod;
    logic [DOY_W-1:0] day_full;
    logic             jan_feb;

    // first day of each March-based month, (153 * mp + 2) / 5
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        take[3] = !vld_reg[3] || !out_stall;
        for (int k = 2; k >= 0; k--)
        begin
            take[k] = !vld_reg[k] || take[k+1];
        end
    end

    assign in_stall  = !take[0];
    assign out_valid = vld_reg[3];
    assign out_beat  = st12_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (take[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < 4; k++)
            begin
                if (take[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign yoe_prod = 37'(in_beat.yoe_days) * 37'(RCP_YEAR);

    always_comb
    begin
        st9_next.yoe = yoe_prod[SH_YEAR+YOE_W-1:SH_YEAR];
        st9_next.doe = in_beat.doe;
        st9_next.era = in_beat.era;
        st9_next.tod = in_beat.tod;
        st9_next.oor = in_beat.oor;
    end

    // day of year: doe - (365 * yoe + yoe / 4 - yoe / 100)
    assign cent_prod = 19'(st9_reg.yoe) * 19'(RCP_CENT);
    assign year_days = DOE_W'(st9_reg.yoe) * DOE_W'(YEAR_DAYS);
    assign doy_full  = st9_reg.doe - year_days - DOE_W'(st9_reg.yoe[YOE_W-1:2])
                     + DOE_W'(cent_prod[SH_CENT+1:SH_CENT]);

    always_comb
    begin
        st10_next.doy = doy_full[DOY_W-1:0];
        st10_next.yoe = st9_reg.yoe;
        st10_next.era = st9_reg.era;
        st10_next.tod = st9_reg.tod;
        st10_next.oor = st9_reg.oor;
    end

    assign mp_arg  = 11'(st10_reg.doy) * 11'(MP_SCALE) + 11'(MP_BIAS);
    assign mp_prod = 23'(mp_arg) * 23'(RCP_MP);

    always_comb
    begin
        st11_next.mp  = mp_prod[SH_MP+MP_W-1:SH_MP];
        st11_next.doy = st10_reg.doy;
        st11_next.yoe = st10_reg.yoe;
        st11_next.era = st10_reg.era;
        st11_next.tod = st10_reg.tod;
        st11_next.oor = st10_reg.oor;
    end

    // January and February belong to the next civil year
    assign jan_feb  = (st11_reg.mp >= MP_JAN);
    assign day_full = st11_reg.doy - month_start(st11_reg.mp) + DOY_W'(1);

    always_comb
    begin
        st12_next.year  = YEAR_W'(st11_reg.yoe) + YEAR_W'(st11_reg.era) * YEAR_W'(YEARS_PER_ERA)
                        + YEAR_W'(jan_feb);
        st12_next.month = jan_feb ? (st11_reg.mp - MP_WRAP) : (st11_reg.mp + MP_TO_MONTH);
        st12_next.day   = day_full[DAY_W-1:0];
        st12_next.tod   = st11_reg.tod;
        st12_next.oor   = st11_reg.oor;
    end

    always_ff @(posedge clk)
    begin
        if (take[0])
        begin
            st9_reg <= st9_next;
        end
        if (take[1])
        begin
            st10_reg <= st10_next;
        end
        if (take[2])
        begin
            st11_reg <= st11_next;
        end
        if (take[3])
        begin
            st12_reg <= st12_next;
        end
    end

endmodule

// ===== hw/rtl/seconds_to_civil_datetime.sv =====
// Converts signed seconds since 1970-01-01 UTC plus a zone offset into a clamped local
// calendar date and time. Twelve register stages, one timestamp per clock while out_stall
// stays low. The pipeline collapses bubbles, so in_stall only rises once all twelve stages
// hold beats while out_stall is high. The depth is set by the chain of constant-reciprocal
// multiplies (day split, era, leap years, year, month), each followed by a register.
// cfg_ready is always high; a zone offset write is scaled to seconds at the write and
// applies to beats accepted afterwards. Local times outside 0000-03-01 00:00:00
// .. 9999-12-31 23:59:59 come out as the nearer limit with out_of_range set.
// depends on stcd_pkg, stcd_day_split, stcd_era_clock, stcd_year_date and the defines header
`include "seconds_to_civil_datetime_defines.svh"

module seconds_to_civil_datetime
    import stcd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic signed [TZ_W-1:0]    tz_offset_minutes,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [EPOCH_W-1:0] epoch_seconds,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [YEAR_W-1:0]         year,
    output logic [MONTH_W-1:0]        month,
    output logic [DAY_W-1:0]          day,
    output logic [HOUR_W-1:0]         hour,
    output logic [MIN_W-1:0]          minute,
    output logic [SEC_W-1:0]          second,
    output logic                      out_of_range
);

    localparam logic signed [TZ_SECS_W-1:0] TZ_SCALE = 18'sd60;

    logic signed [TZ_SECS_W-1:0] tz_secs_reg, tz_secs_next;
    logic signed [TZ_SECS_W-1:0] tz_wide;

    logic       split_valid, split_stall;
    day_split_t split_beat;
    logic       era_valid, era_stall;
    era_clock_t era_beat;
    civil_t     civil_beat;

    logic                        date_legal;
    logic                        clock_legal;
    logic                        at_clamp_limit;
    logic signed [TZ_SECS_W-1:0] tz_ref;

    assign cfg_ready = 1'b1;

    // minutes to seconds as 64x - 4x
    assign tz_wide      = {{(TZ_SECS_W-TZ_W){tz_offset_minutes[TZ_W-1]}}, tz_offset_minutes};
    assign tz_secs_next = (tz_wide <<< 6) - (tz_wide <<< 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_secs_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tz_secs_reg <= tz_secs_next;
        end
    end

    stcd_day_split u_day_split
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .epoch_seconds (epoch_seconds),
        .tz_secs       (tz_secs_reg),
        .out_valid     (split_valid),
        .out_stall     (split_stall),
        .out_beat      (split_beat)
    );

    stcd_era_clock u_era_clock
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (split_valid),
        .in_stall  (split_stall),
        .in_beat   (split_beat),
        .out_valid (era_valid),
        .out_stall (era_stall),
        .out_beat  (era_beat)
    );

    stcd_year_date u_year_date
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (era_valid),
        .in_stall  (era_stall),
        .in_beat   (era_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (civil_beat)
    );

    assign year         = civil_beat.year;
    assign month        = civil_beat.month;
    assign day          = civil_beat.day;
    assign hour         = civil_beat.tod.hour;
    assign minute       = civil_beat.tod.minute;
    assign second       = civil_beat.tod.second;
    assign out_of_range = civil_beat.oor;

    assign date_legal     = year <= 14'd9999 && month >= 4'd1 && month <= 4'd12
                         && day >= 5'd1 && day <= 5'd31;
    assign clock_legal    = hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59;
    assign at_clamp_limit = (year == 14'd0 && month == 4'd3 && day == 5'd1
                             && hour == 5'd0 && minute == 6'd0 && second == 6'd0)
                         || (year == 14'd9999 && month == 4'd12 && day == 5'd31
                             && hour == 5'd23 && minute == 6'd59 && second == 6'd59);
    assign tz_ref         = TZ_SECS_W'(tz_offset_minutes) * TZ_SCALE;

    `STCD_ASSERT_IMP(a_date_legal, clk, rst_n, out_valid, date_legal)
    `STCD_ASSERT_IMP(a_clock_legal, clk, rst_n, out_valid, clock_legal)
    `STCD_ASSERT_IMP(a_clamp_limits, clk, rst_n, out_valid && out_of_range, at_clamp_limit)
    `STCD_ASSERT_NEXT(a_tz_scale, clk, rst_n, cfg_valid && cfg_ready, tz_secs_reg == $past(tz_ref))

endmodule

// ===== verif/tb_seconds_to_civil_datetime.sv =====
// self-checking testbench for seconds_to_civil_datetime: converts random and edge timestamps
// under several zone offsets, with stalls on both sides, and checks every result beat
// depends on stcd_pkg and the seconds_to_civil_datetime rtl
`timescale 1ns / 100ps

module tb_seconds_to_civil_datetime;
    import stcd_pkg::*;

    localparam int    NUM_PHASES   = 6;
    localparam int    RANDOM_ITEMS = 125;
    localparam int    HOLD_CYCLES  = 64;
    localparam int    DRAIN_CYCLES = 24;
    localparam int    CYCLE_LIMIT  = 200000;

    localparam longint FIRST_LOCAL  = -64'sd62162035200;
    localparam longint LAST_LOCAL   = 64'sd253402300799;
    localparam longint LOCAL_SPAN   = LAST_LOCAL - FIRST_LOCAL + 1;
    localparam longint SECS_DAY     = 86400;
    localparam longint DAYS_ERA     = 146097;
    localparam longint SECS_HOUR    = 3600;
    localparam longint SECS_MINUTE  = 60;
    localparam longint DAYS_IN_SPAN = LOCAL_SPAN / SECS_DAY;

    localparam int NUM_DIRECTED = 22;
    localparam longint DIRECTED_EPOCHS [NUM_DIRECTED] = '{
        0, -1, 86399, 86400, -86400, -86401,
        FIRST_LOCAL, FIRST_LOCAL - 1, FIRST_LOCAL + 86399,
        LAST_LOCAL, LAST_LOCAL + 1,
        -64'sd274877906944, 64'sd274877906943,
        951782400, 951868800,                    // around the 2000 leap day
        -64'sd2203977600, -64'sd2203891200,      // end of february 1900, not a leap year
        64'sd4107456000, 64'sd4107542400,        // end of february 2100, not a leap year
        946684799, 2147483647, 64'sd2147483648
    };

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic               oor;
    } datetime_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic signed [TZ_W-1:0]    tz_offset_minutes = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [EPOCH_W-1:0] epoch_seconds = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [YEAR_W-1:0]         year;
    logic [MONTH_W-1:0]        month;
    logic [DAY_W-1:0]          day;
    logic [HOUR_W-1:0]         hour;
    logic [MIN_W-1:0]          minute;
    logic [SEC_W-1:0]          second;
    logic                      out_of_range;

    logic signed [EPOCH_W-1:0] pending_epochs[$];
    datetime_t                 expected_dates[$];
    logic signed [TZ_W-1:0]    tz_now = '0;
    int                        send_idle_pct = 0;
    int                        recv_idle_pct = 0;
    logic                      hold_off = 1'b0;
    bit                        hold_go = 1'b0;
    int                        failures = 0;
    int                        stamps_in = 0;
    int                        clamped_count = 0;
    int                        input_stall_cycles = 0;
    int                        cycle_count = 0;

    seconds_to_civil_datetime DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .tz_offset_minutes (tz_offset_minutes),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .epoch_seconds     (epoch_seconds),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .year              (year),
        .month             (month),
        .day               (day),
        .hour              (hour),
        .minute            (minute),
        .second            (second),
        .out_of_range      (out_of_range)
    );

    always #5 clk = ~clk;

    // local time = epoch + offset, clamped, then split on a march-based year
    function automatic datetime_t civil_from_epoch(logic signed [EPOCH_W-1:0] epoch,
                                                   logic signed [TZ_W-1:0] tz);
        longint    loc_secs;
        longint    s;
        longint    days;
        longint    sod;
        longint    era;
        longint    doe;
        longint    yoe;
        longint    doy;
        longint    mp;
        longint    mon;
        datetime_t r;
        loc_secs = longint'(epoch) + longint'(tz) * SECS_MINUTE;
        r.oor = 1'b0;
        if (loc_secs < FIRST_LOCAL)
        begin
            loc_secs = FIRST_LOCAL;
            r.oor = 1'b1;
        end
        else if (loc_secs > LAST_LOCAL)
        begin
            loc_secs = LAST_LOCAL;
            r.oor = 1'b1;
        end
        s    = loc_secs - FIRST_LOCAL;
        days = s / SECS_DAY;
        sod  = s % SECS_DAY;
        era  = days / DAYS_ERA;
        doe  = days - era * DAYS_ERA;
        yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp   = (5 * doy + 2) / 153;
        mon  = (mp < 10) ? mp + 3 : mp - 9;
        r.day    = DAY_W'(doy - (153 * mp + 2) / 5 + 1);
        r.month  = MONTH_W'(mon);
        r.year   = YEAR_W'(yoe + era * 400 + ((mon <= 2) ? 1 : 0));
        r.hour   = HOUR_W'(sod / SECS_HOUR);
        r.minute = MIN_W'((sod % SECS_HOUR) / SECS_MINUTE);
        r.second = SEC_W'(sod % SECS_MINUTE);
        return r;
    endfunction

    // mostly in-range times, with extra weight on the clamp edges and on midnight
    function automatic logic signed [EPOCH_W-1:0] random_epoch(logic signed [TZ_W-1:0] tz);
        logic [63:0] r;
        longint      shift;
        longint      x;
        r     = {$urandom, $urandom};
        shift = longint'(tz) * SECS_MINUTE;
        case ($urandom_range(9))
            0, 1: x = longint'(r[EPOCH_W-1:0]) - (longint'(r[EPOCH_W-1]) << EPOCH_W);
            2:    x = FIRST_LOCAL - shift + longint'($urandom_range(400)) - 200;
            3:    x = LAST_LOCAL - shift + longint'($urandom_range(400)) - 200;
            4:    x = FIRST_LOCAL - shift
                      + longint'($urandom_range(DAYS_IN_SPAN - 1)) * SECS_DAY
                      + longint'($urandom_range(4)) - 2;
            default: x = FIRST_LOCAL - shift + longint'(r >> 1) % LOCAL_SPAN;
        endcase
        return EPOCH_W'(x);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    // driver: one beat per accepted handshake, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin : drive
        logic                      next_valid;
        logic signed [EPOCH_W-1:0] next_epoch;
        datetime_t                 civil;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            epoch_seconds <= '0;
        end
        else
        begin
            next_valid = in_valid;
            next_epoch = epoch_seconds;
            if (in_valid && in_stall)
                input_stall_cycles++;
            if (in_valid && !in_stall)
            begin
                civil = civil_from_epoch(epoch_seconds, tz_now);
                expected_dates.push_back(civil);
                stamps_in++;
                if (civil.oor)
                    clamped_count++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_epochs.size() != 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                next_epoch = pending_epochs.pop_front();
                next_valid = 1'b1;
            end
            in_valid      <= next_valid;
            epoch_seconds <= next_epoch;
        end
    end

    // monitor: compare each output beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch
        datetime_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_dates.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %0d-%0d-%0d",
                             $time, year, month, day);
                    $display("%0t:   actual time %0d:%0d:%0d oor=%0b",
                             $time, hour, minute, second, out_of_range);
                    failures++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    check_field("year", want.year, year);
                    check_field("month", want.month, month);
                    check_field("day", want.day, day);
                    check_field("hour", want.hour, hour);
                    check_field("minute", want.minute, minute);
                    check_field("second", want.second, second);
                    check_field("out_of_range", want.oor, out_of_range);
                end
            end
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // long receiver hold-off so the pipeline fills and pushes back on the input
    initial
    begin : pressure
        int k;
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, expected_dates.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic signed [TZ_W-1:0] zone_offsets [NUM_PHASES];
        logic signed [TZ_W-1:0] tz_next;
        longint                 low_edge;
        longint                 high_edge;
        int                     p;
        int                     i;
        zone_offsets[0] = 12'sd0;
        zone_offsets[1] = 12'sd2047;
        zone_offsets[2] = -12'sd2048;
        zone_offsets[3] = 12'sd1440;
        zone_offsets[4] = -12'sd1440;
        zone_offsets[5] = TZ_W'($urandom);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // offset changes only with the pipeline empty
            do @(posedge clk);
            while (pending_epochs.size() != 0 || in_valid || expected_dates.size() != 0);

            tz_next = zone_offsets[p];
            @(posedge clk);
            cfg_valid         <= 1'b1;
            tz_offset_minutes <= tz_next;
            do @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            tz_now = tz_next;

            if (p < 2)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 45;
            end
            else if (p < 4)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (p == 0)
                for (i = 0; i < NUM_DIRECTED; i++)
                    pending_epochs.push_back(EPOCH_W'(DIRECTED_EPOCHS[i]));

            // clamp edges as seen through this offset
            low_edge  = FIRST_LOCAL - longint'(tz_now) * SECS_MINUTE;
            high_edge = LAST_LOCAL - longint'(tz_now) * SECS_MINUTE;
            pending_epochs.push_back(EPOCH_W'(low_edge - 1));
            pending_epochs.push_back(EPOCH_W'(low_edge));
            pending_epochs.push_back(EPOCH_W'(high_edge));
            pending_epochs.push_back(EPOCH_W'(high_edge + 1));

            for (i = 0; i < RANDOM_ITEMS; i++)
                pending_epochs.push_back(random_epoch(tz_now));

            if (p == NUM_PHASES - 1)
                hold_go = 1'b1;
        end

        do @(posedge clk);
        while (pending_epochs.size() != 0 || in_valid || expected_dates.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("converted %0d timestamps under %0d zone offsets, %0d of them clamped",
                 stamps_in, NUM_PHASES, clamped_count);
        $display("input held back by the block for %0d cycles, %0d mismatches",
                 input_stall_cycles, failures);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
